>>> rtl/mfw_pkg.sv
// Shared types, constants and helper functions of the median filter window.
// Used by the controller, the datapath and the top level; depends on nothing.
package mfw_pkg;

  localparam int MaxLine   = 1024;
  localparam int MaxWindow = 7;
  localparam int Lines     = MaxWindow - 1;
  localparam int Taps      = MaxWindow * MaxWindow;
  localparam int ColW      = $clog2(MaxLine);
  localparam int CntW      = $clog2(Taps + 1);

  localparam logic [2:0] RegImageWidth   = 3'd0;
  localparam logic [2:0] RegImageHeight  = 3'd1;
  localparam logic [2:0] RegWindowWidth  = 3'd2;
  localparam logic [2:0] RegWindowHeight = 3'd3;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StSel  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  typedef struct packed {
    logic accept;
    logic shift;
    logic sel_start;
    logic sel_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic sel_done;
    logic out_busy;
  } status_t;

  // Window size rounded down to odd, zero taken as one.
  function automatic logic [2:0] eff_window(input logic [2:0] w);
    logic [2:0] v;
    v = (w == 3'd0) ? 3'd1 : w;
    return (v - 3'd1) | 3'd1;
  endfunction

  function automatic logic [10:0] eff_width(input logic [10:0] w);
    logic [10:0] v;
    v = (w == 11'd0) ? 11'd1 : w;
    return (v > 11'(MaxLine)) ? 11'(MaxLine) : v;
  endfunction

  function automatic logic [11:0] eff_height(input logic [11:0] h);
    return (h == 12'd0) ? 12'd1 : h;
  endfunction

endpackage

>>> rtl/mfw_ctrl.sv
// Controller state machine of the median filter window.
// Depends on mfw_pkg; drives the datapath through command and status structs.
module mfw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mfw_pkg::status_t status_i,
  output mfw_pkg::cmd_t    cmd_o
);

  mfw_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == mfw_pkg::StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      mfw_pkg::StIdle: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = mfw_pkg::StRead;
      end
      mfw_pkg::StRead: begin
        cmd_o.shift     = 1'b1;
        cmd_o.sel_start = status_i.emit;
        state_d = status_i.emit ? mfw_pkg::StSel : mfw_pkg::StIdle;
      end
      mfw_pkg::StSel: begin
        cmd_o.sel_step = 1'b1;
        if (status_i.sel_done) state_d = mfw_pkg::StOut;
      end
      mfw_pkg::StOut: begin
        // Wait here while the previous result has not yet been taken.
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = mfw_pkg::StIdle;
        end
      end
      default: state_d = mfw_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= mfw_pkg::StIdle;
    else         state_q <= state_d;
  end

endmodule

>>> rtl/mfw_datapath.sv
// Datapath of the median filter window: registers, line buffers, window and
// the bitwise rank selector. Depends on mfw_pkg; steered by mfw_ctrl.
module mfw_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [11:0]      cfg_data_i,
  input  logic [7:0]       pixel_i,
  input  mfw_pkg::cmd_t    cmd_i,
  output mfw_pkg::status_t status_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       median_value_o,
  output logic             last_in_row_o,
  output logic             last_in_frame_o
);

  logic [10:0] img_w_q;
  logic [11:0] img_h_q;
  logic [2:0]  win_w_q, win_h_q;
  logic [mfw_pkg::ColW-1:0] col_q;
  logic [11:0] row_q;
  logic        cfg_hit;

  logic [7:0] pixel_q;
  logic [7:0] rd_q [mfw_pkg::Lines];
  logic [7:0] win_q [mfw_pkg::MaxWindow][mfw_pkg::MaxWindow];
  logic [7:0] col_v [mfw_pkg::MaxWindow];

  logic [10:0] ew;
  logic [11:0] eh;
  logic [2:0]  eww, ewh;
  logic        row_end, frame_end;

  logic [7:0]  prefix_q, mask_q, bsel_q;
  logic [5:0]  rank_q;
  logic [mfw_pkg::CntW-1:0] cnt;
  logic        last_row_q, last_frame_q;
  logic        out_valid_q;
  logic [7:0]  out_val_q;
  logic        out_row_q, out_frame_q;
  logic [5:0]  taps;

  assign ew  = mfw_pkg::eff_width(img_w_q);
  assign eh  = mfw_pkg::eff_height(img_h_q);
  assign eww = mfw_pkg::eff_window(win_w_q);
  assign ewh = mfw_pkg::eff_window(win_h_q);
  assign taps = 6'(eww) * 6'(ewh);

  assign row_end   = ({1'b0, col_q} + 11'd1) >= ew;
  assign frame_end = row_end && (({1'b0, row_q} + 13'd1) >= {1'b0, eh});

  assign status_o.emit = (({1'b0, row_q} + 13'd1) >= 13'(ewh)) &&
                         (({1'b0, col_q} + 11'd1) >= 11'(eww));
  assign status_o.sel_done = bsel_q[0];
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign cfg_hit = cfg_we_i && (cfg_index_i == mfw_pkg::RegImageWidth ||
                   cfg_index_i == mfw_pkg::RegImageHeight ||
                   cfg_index_i == mfw_pkg::RegWindowWidth ||
                   cfg_index_i == mfw_pkg::RegWindowHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 11'd640;
      img_h_q <= 12'd480;
      win_w_q <= 3'd3;
      win_h_q <= 3'd3;
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_hit) begin
      case (cfg_index_i)
        mfw_pkg::RegImageWidth:  img_w_q <= cfg_data_i[10:0];
        mfw_pkg::RegImageHeight: img_h_q <= cfg_data_i;
        mfw_pkg::RegWindowWidth: win_w_q <= cfg_data_i[2:0];
        default:                 win_h_q <= cfg_data_i[2:0];
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.shift) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_end ? 12'd0 : row_q + 12'd1;
      end else begin
        col_q <= col_q + {{(mfw_pkg::ColW-1){1'b0}}, 1'b1};
      end
    end
  end

  // The new column, newest row first.
  always_comb begin
    col_v[0] = pixel_q;
    for (int k = 1; k < mfw_pkg::MaxWindow; k++) col_v[k] = rd_q[k-1];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) pixel_q <= pixel_i;
  end

  // One line buffer per previous row, each read and written at the column.
  for (genvar g = 0; g < mfw_pkg::Lines; g++) begin : g_line
    logic [7:0] mem_q [mfw_pkg::MaxLine];
    always_ff @(posedge clk_i) begin
      if (cmd_i.accept) rd_q[g] <= mem_q[col_q];
      if (cmd_i.shift)  mem_q[col_q] <= col_v[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      for (int k = 0; k < mfw_pkg::MaxWindow; k++) begin
        for (int j = 0; j < mfw_pkg::MaxWindow - 1; j++) win_q[k][j] <= win_q[k][j+1];
        win_q[k][mfw_pkg::MaxWindow-1] <= col_v[k];
      end
    end
  end

  // Count the window taps that match the decided prefix and hold a zero at
  // the bit under test.
  always_comb begin
    cnt = '0;
    for (int k = 0; k < mfw_pkg::MaxWindow; k++) begin
      for (int j = 0; j < mfw_pkg::MaxWindow; j++) begin
        if ((k < int'(ewh)) && (j >= mfw_pkg::MaxWindow - int'(eww)) &&
            (((win_q[k][j] ^ prefix_q) & mask_q) == 8'd0) &&
            ((win_q[k][j] & bsel_q) == 8'd0))
          cnt = cnt + {{(mfw_pkg::CntW-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsel_q <= '0;
    end else if (cmd_i.sel_start) begin
      bsel_q <= 8'h80;
    end else if (cmd_i.sel_step) begin
      bsel_q <= bsel_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_start) begin
      prefix_q     <= '0;
      mask_q       <= '0;
      rank_q       <= taps >> 1;
      last_row_q   <= row_end;
      last_frame_q <= frame_end;
    end else if (cmd_i.sel_step) begin
      mask_q <= mask_q | bsel_q;
      if (rank_q >= 6'(cnt)) begin
        prefix_q <= prefix_q | bsel_q;
        rank_q   <= rank_q - 6'(cnt);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)               out_valid_q <= 1'b0;
    else if (cmd_i.load_out)   out_valid_q <= 1'b1;
    else if (out_ready_i)      out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_val_q   <= prefix_q;
      out_row_q   <= last_row_q;
      out_frame_q <= last_frame_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign median_value_o  = out_val_q;
  assign last_in_row_o   = out_row_q;
  assign last_in_frame_o = out_frame_q;

endmodule

>>> rtl/median_filter_window.sv
// Each input transaction for a position that yields a median passes through
// line buffer read, window shift, eight rank-select steps and output load;
// positions outside the valid region return to idle after the window shift.
// A new pixel is accepted only after the previous one is done, rank select and result hand-off included.
// Reset is asynchronous and active low: counters clear, registers take
// 640 x 480 with a 3 x 3 window; buffer contents stay undefined.
module median_filter_window (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  median_value_o,
  output logic        last_in_row_o,
  output logic        last_in_frame_o
);

  mfw_pkg::cmd_t    cmd;
  mfw_pkg::status_t status;

  mfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mfw_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pixel_i         (pixel_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .median_value_o  (median_value_o),
    .last_in_row_o   (last_in_row_o),
    .last_in_frame_o (last_in_frame_o)
  );

endmodule

>>> rtl/mfw_checker.sv
// Port-level checks of the median filter window, bound to the top level.
// Depends only on the ports of median_filter_window.
module mfw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] median_value_o
);

  // A result cannot appear in the cycle straight after a transaction.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o))
    else $error("result too soon after input transaction");

  // The block works on one pixel at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(median_value_o)))
    else $error("stalled result changed");

endmodule

bind median_filter_window mfw_checker u_mfw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .median_value_o (median_value_o)
);
